FILE: sv/uv_sphere_grid_point_generator_assert.svh
// ----------------------------------------------------------------------------
// uv sphere grid point generator assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_GRID_POINT_GENERATOR_ASSERT_SVH
`define UV_SPHERE_GRID_POINT_GENERATOR_ASSERT_SVH
`ifndef SYNTH
`define UVSG_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uvsg check failed");
`define UVSG_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uvsg sequence check failed");
`else
`define UVSG_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define UVSG_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: sv/uvsg_pkg.sv
// ----------------------------------------------------------------------------
// uvsg_pkg
// shared widths, coefficients, codes and item types of the sphere generator
// ----------------------------------------------------------------------------
package uvsg_pkg;

   localparam int MAX_RINGS    = 256;
   localparam int MAX_SEGMENTS = 256;
   localparam int ANGLE_BITS   = 16;
   localparam int TEX_FRAC     = 16;

   localparam int CNT_W = 9;
   localparam int RAD_W = 16;
   localparam int IDX_W = 17;
   localparam int NRM_W = 16;
   localparam int POS_W = 17;
   localparam int TEX_W = 17;

   localparam int REQ_W = 24;
   localparam int RSP_W = 184;
   localparam int CSR_AW = 2;
   localparam int CSR_DW = 16;

   // pipelined divider: quotient bits and remainder width
   localparam int QUO_W = 17;
   localparam int REM_W = 9;
   localparam int DIV_W = REM_W + 1;
   localparam int NUM_W = QUO_W + REM_W;
   localparam int LANES = 4;

   // sine polynomial, Q30
   localparam int Z_W  = 32;
   localparam int FRAC = 30;
   localparam logic [Z_W-1:0] ONE30 = Z_W'(1) << FRAC;
   localparam logic [Z_W-1:0] K1 = 32'd1686629713;
   localparam logic [Z_W-1:0] K3 = 32'd693598668;
   localparam logic [Z_W-1:0] K5 = 32'd85569306;
   localparam logic [Z_W-1:0] K7 = 32'd5026995;
   localparam logic [Z_W-1:0] K9 = 32'd172272;
   localparam int HORN_N = 4;
   localparam logic [Z_W-1:0] HORNER_K [HORN_N] = '{K7, K5, K3, K1};
   localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   localparam logic [CSR_AW-1:0] CSR_RING_COUNT    = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_SEGMENT_COUNT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_RADIUS        = 2'd2;

   typedef enum logic [1:0] {
      KIND_VERT_MORE = 2'd0,
      KIND_VERT_LAST = 2'd1,
      KIND_TRI_MORE  = 2'd2,
      KIND_TRI_LAST  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      TRI_TOP,
      TRI_BOT,
      TRI_MID
   } tri_kind_type;

   typedef struct packed {
      tri_kind_type     tk;
      logic             has_tri;
      logic [IDX_W-1:0] v0;
      logic [IDX_W-1:0] v1;
      logic [IDX_W-1:0] v2;
      logic [IDX_W-1:0] v3;
   } side_type;

   typedef struct packed {
      side_type                side;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic signed [NRM_W-1:0] nz;
      logic signed [POS_W-1:0] px;
      logic signed [POS_W-1:0] py;
      logic signed [POS_W-1:0] pz;
      logic [TEX_W-1:0]        tu;
      logic [TEX_W-1:0]        tv;
   } item_type;

   typedef struct packed {
      logic     load;
      item_type item;
   } load_type;

endpackage

FILE: sv/uvsg_div_cell.sv
// ----------------------------------------------------------------------------
// uvsg_div_cell
// one restoring division step: shifts in a numerator bit, emits a quotient bit
// ----------------------------------------------------------------------------
module uvsg_div_cell (
   input  logic                       clock,
   input  logic                       en,
   input  logic [uvsg_pkg::DIV_W-1:0] d_i,
   input  logic [uvsg_pkg::REM_W-1:0] rem_i,
   input  logic [uvsg_pkg::QUO_W-1:0] wrk_i,
   output logic [uvsg_pkg::REM_W-1:0] rem_o,
   output logic [uvsg_pkg::QUO_W-1:0] wrk_o
);
   import uvsg_pkg::*;

   logic [DIV_W-1:0] trial;
   logic             ge;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] wrk_ff, wrk_in;

   // wrk holds the numerator bits still to come, quotient bits enter below
   always_comb begin
      trial  = {rem_i, wrk_i[QUO_W-1]};
      ge     = (trial >= d_i);
      rem_in = ge ? REM_W'(trial - d_i) : REM_W'(trial);
      wrk_in = {wrk_i[QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         wrk_ff <= wrk_in;
      end
   end

   assign rem_o = rem_ff;
   assign wrk_o = wrk_ff;
endmodule

FILE: sv/uvsg_horner_cell.sv
// ----------------------------------------------------------------------------
// uvsg_horner_cell
// one step of the sine polynomial: a = COEF - a*z^2, Q30
// ----------------------------------------------------------------------------
module uvsg_horner_cell #(
   parameter logic [31:0] COEF = 32'd0
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [uvsg_pkg::Z_W-1:0] a_i,
   input  logic [uvsg_pkg::Z_W-1:0] z_i,
   input  logic [uvsg_pkg::Z_W-1:0] z2_i,
   input  logic                     neg_i,
   output logic [uvsg_pkg::Z_W-1:0] a_o,
   output logic [uvsg_pkg::Z_W-1:0] z_o,
   output logic [uvsg_pkg::Z_W-1:0] z2_o,
   output logic                     neg_o
);
   import uvsg_pkg::*;

   logic [2*Z_W-1:0] prod;
   logic [Z_W-1:0]   a_ff, a_in, z_ff, z2_ff;
   logic             neg_ff;

   always_comb begin
      prod = (2*Z_W)'(a_i) * (2*Z_W)'(z2_i);
      a_in = COEF - prod[FRAC+Z_W-1:FRAC];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= a_in;
         z_ff   <= z_i;
         z2_ff  <= z2_i;
         neg_ff <= neg_i;
      end
   end

   assign a_o   = a_ff;
   assign z_o   = z_ff;
   assign z2_o  = z2_ff;
   assign neg_o = neg_ff;
endmodule

FILE: sv/uvsg_out_seq.sv
// ----------------------------------------------------------------------------
// uvsg_out_seq
// holds one finished grid point and sends its vertex and triangle results
// ----------------------------------------------------------------------------
module uvsg_out_seq (
   input  logic                       clock,
   input  logic                       reset,
   input  uvsg_pkg::load_type         ld_i,
   output logic                       ld_ok_o,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // index_a, index_b, index_c, normal_x/y/z, position_x/y/z, tex_u, tex_v
   output logic [uvsg_pkg::RSP_W-1:0] rsp_tdata,
   // kind
   output logic [1:0]                 rsp_tuser
);
   import uvsg_pkg::*;

   typedef enum logic [1:0] {
      STEP_VERT,
      STEP_TRI1,
      STEP_TRI2
   } step_type;

   step_type  step_ff;
   logic      busy_ff;
   item_type  item_ff;
   logic      last;
   kind_type  kind;
   logic [IDX_W-1:0] ia, ib, ic;
   logic      vert;

   always_comb begin
      last = 1'b0;
      kind = KIND_TRI_LAST;
      ia   = item_ff.side.v0;
      ib   = '0;
      ic   = '0;
      vert = 1'b0;
      unique case (step_ff)
         STEP_VERT: begin
            last = !item_ff.side.has_tri;
            kind = item_ff.side.has_tri ? KIND_VERT_MORE : KIND_VERT_LAST;
            vert = 1'b1;
         end
         STEP_TRI1: begin
            last = (item_ff.side.tk != TRI_MID);
            kind = (item_ff.side.tk == TRI_MID) ? KIND_TRI_MORE : KIND_TRI_LAST;
            ib   = item_ff.side.v1;
            ic   = item_ff.side.v2;
         end
         STEP_TRI2: begin
            last = 1'b1;
            ia   = item_ff.side.v1;
            ib   = item_ff.side.v3;
            ic   = item_ff.side.v2;
         end
         default: begin
            last = 1'b1;
         end
      endcase
   end

   assign ld_ok_o    = !busy_ff || (last && rsp_tready);
   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = kind;
   assign rsp_tdata  = vert ?
      {item_ff.tv, item_ff.tu, item_ff.pz, item_ff.py, item_ff.px,
       item_ff.nz, item_ff.ny, item_ff.nx, ic, ib, ia} :
      {(RSP_W - 3*IDX_W)'(0), ic, ib, ia};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_VERT;
      end else if (ld_i.load) begin
         busy_ff <= 1'b1;
         step_ff <= STEP_VERT;
         item_ff <= ld_i.item;
      end else if (busy_ff && rsp_tready) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            step_ff <= (step_ff == STEP_VERT) ? STEP_TRI1 : STEP_TRI2;
         end
      end
   end
endmodule

FILE: sv/uv_sphere_grid_point_generator.sv
// Results leave one per cycle while rsp_tready is high. A point gives 1 to 3
// results, sent in turn by the output sequencer; the cell chains take a new
// point every cycle unless a finished point waits on the output sequencer and
// stalls them. Reset clears all valid flags and the output sequencer and sets
// ring_count 16, segment_count 32, radius 1.0.
// ----------------------------------------------------------------------------
// uv_sphere_grid_point_generator
// sphere grid point to vertex and triangle results via divider and sine cells
// ----------------------------------------------------------------------------
`include "uv_sphere_grid_point_generator_assert.svh"

module uv_sphere_grid_point_generator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // ring, segment
   input  logic [uvsg_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // index_a, index_b, index_c, normal_x/y/z, position_x/y/z, tex_u, tex_v
   output logic [uvsg_pkg::RSP_W-1:0]  rsp_tdata,
   // kind
   output logic [1:0]                  rsp_tuser,
   input  logic                        csr_we,
   input  logic [uvsg_pkg::CSR_AW-1:0] csr_addr,
   input  logic [uvsg_pkg::CSR_DW-1:0] csr_wdata
);
   import uvsg_pkg::*;

   localparam int ST_FOLD = QUO_W + 1;
   localparam int ST_SINE = ST_FOLD + HORN_N + 1;
   localparam int ST_NORM = ST_SINE + 1;
   localparam int ST_LAST = ST_NORM + 1;
   localparam int AB = ANGLE_BITS;

   // configuration
   logic [CNT_W-1:0] ring_count_ff, segment_count_ff;
   logic [RAD_W-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= CNT_W'(16);
         segment_count_ff <= CNT_W'(32);
         radius_ff        <= RAD_W'(256);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RING_COUNT:    ring_count_ff    <= csr_wdata[CNT_W-1:0];
            CSR_SEGMENT_COUNT: segment_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_RADIUS:        radius_ff        <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   logic [CNT_W-1:0] rings, segs;
   logic [DIV_W-1:0] dvs [LANES];

   always_comb begin
      rings = (ring_count_ff > CNT_W'(MAX_RINGS)) ? CNT_W'(MAX_RINGS) : ring_count_ff;
      segs  = (segment_count_ff > CNT_W'(MAX_SEGMENTS)) ?
              CNT_W'(MAX_SEGMENTS) : segment_count_ff;
      dvs[0] = {rings, 1'b0};
      dvs[1] = {1'b0, segs};
      dvs[2] = {segs, 1'b0};
      dvs[3] = {1'b0, rings};
   end

   // pipeline control
   logic     adv;
   logic     ld_ok;
   load_type ld;
   logic     vld_ff [0:ST_LAST];
   side_type side_ff [0:ST_LAST];

   assign req_tready = adv;

   // front: checks, indices and division numerators
   logic [CNT_W-1:0] r, s;
   logic             pole, emit;
   side_type         side_in;
   logic [CNT_W:0]   sp1;
   logic [18:0]      m, row_r, row_r1, s0, s1;
   logic [NUM_W-1:0] num [LANES];

   always_comb begin
      r    = req_tdata[CNT_W-1:0];
      s    = req_tdata[2*CNT_W-1:CNT_W];
      pole = (r == '0) || (r == rings);
      emit = (rings != '0) && (segs != '0) && (r <= rings) && (s <= segs) &&
             !(pole && (s == segs));
      sp1    = {1'b0, segs} + (CNT_W+1)'(1);
      m      = 19'(r) * 19'(sp1);
      row_r  = (r == '0) ? 19'd0 : m - 19'd1;
      row_r1 = m + 19'(sp1) - 19'd1;
      s0     = 19'(s);
      s1     = 19'(s) + 19'd1;
      side_in.has_tri = (r < rings) && (s < segs);
      if (r == '0) begin
         side_in.tk = TRI_TOP;
      end else if (r == rings - CNT_W'(1)) begin
         side_in.tk = TRI_BOT;
      end else begin
         side_in.tk = TRI_MID;
      end
      side_in.v0 = IDX_W'(row_r + s0);
      side_in.v1 = (r == '0) ? IDX_W'(row_r1 + s1) : IDX_W'(row_r + s1);
      side_in.v2 = IDX_W'(row_r1 + s0);
      side_in.v3 = IDX_W'(row_r1 + s1);
      num[0] = (NUM_W'(r) << AB) + NUM_W'(rings);
      num[1] = (NUM_W'(s) << AB) + NUM_W'(segs >> 1);
      num[2] = ((NUM_W'(s) << 1) + NUM_W'(pole)) << TEX_FRAC;
      num[2] = num[2] + NUM_W'(segs);
      num[3] = (NUM_W'(r) << TEX_FRAC) + NUM_W'(rings >> 1);
   end

   // stage 0 registers
   logic [REM_W-1:0] dv0_rem_ff [LANES];
   logic [QUO_W-1:0] dv0_wrk_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_tvalid && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int l = 0; l < LANES; l++) begin
            dv0_rem_ff[l] <= num[l][NUM_W-1:QUO_W];
            dv0_wrk_ff[l] <= num[l][QUO_W-1:0];
         end
      end
   end

   for (genvar k = 1; k <= ST_LAST; k++) begin : g_pipe
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // divider chain
   logic [REM_W-1:0] dv_rem [0:QUO_W][LANES];
   logic [QUO_W-1:0] dv_wrk [0:QUO_W][LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_dv0
      assign dv_rem[0][l] = dv0_rem_ff[l];
      assign dv_wrk[0][l] = dv0_wrk_ff[l];
   end

   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         uvsg_div_cell u_div (
            .clock (clock),
            .en    (adv),
            .d_i   (dvs[l]),
            .rem_i (dv_rem[k][l]),
            .wrk_i (dv_wrk[k][l]),
            .rem_o (dv_rem[k+1][l]),
            .wrk_o (dv_wrk[k+1][l])
         );
      end
   end

   // phases, quadrant fold and z^2
   logic [AB-1:0]    ph [LANES];
   logic [Z_W-1:0]   fz [LANES];
   logic [2*Z_W-1:0] fsq [LANES];
   logic [Z_W-1:0]   fz_ff [LANES];
   logic [Z_W-1:0]   fz2_ff [LANES];
   logic             fneg_ff [LANES];
   logic [TEX_W-1:0] tu_ff [ST_FOLD:ST_LAST];
   logic [TEX_W-1:0] tv_ff [ST_FOLD:ST_LAST];

   always_comb begin
      ph[0] = dv_wrk[QUO_W][0][AB-1:0];
      ph[1] = dv_wrk[QUO_W][0][AB-1:0] + QUARTER;
      ph[2] = dv_wrk[QUO_W][1][AB-1:0];
      ph[3] = dv_wrk[QUO_W][1][AB-1:0] + QUARTER;
      for (int l = 0; l < LANES; l++) begin
         fz[l] = Z_W'(ph[l][AB-3:0]) << (Z_W - AB);
         if (ph[l][AB-2]) begin
            fz[l] = ONE30 - fz[l];
         end
         fsq[l] = (2*Z_W)'(fz[l]) * (2*Z_W)'(fz[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            fz_ff[l]   <= fz[l];
            fz2_ff[l]  <= fsq[l][FRAC+Z_W-1:FRAC];
            fneg_ff[l] <= ph[l][AB-1];
         end
         tu_ff[ST_FOLD] <= TEX_W'(1 << TEX_FRAC) - dv_wrk[QUO_W][2];
         tv_ff[ST_FOLD] <= dv_wrk[QUO_W][3];
      end
   end

   for (genvar k = ST_FOLD + 1; k <= ST_LAST; k++) begin : g_tex
      always_ff @(posedge clock) begin
         if (adv) begin
            tu_ff[k] <= tu_ff[k-1];
            tv_ff[k] <= tv_ff[k-1];
         end
      end
   end

   // polynomial chain
   logic [Z_W-1:0] h_a  [0:HORN_N][LANES];
   logic [Z_W-1:0] h_z  [0:HORN_N][LANES];
   logic [Z_W-1:0] h_z2 [0:HORN_N][LANES];
   logic           h_neg [0:HORN_N][LANES];

   for (genvar l = 0; l < LANES; l++) begin : g_h0
      assign h_a[0][l]   = K9;
      assign h_z[0][l]   = fz_ff[l];
      assign h_z2[0][l]  = fz2_ff[l];
      assign h_neg[0][l] = fneg_ff[l];
   end

   for (genvar k = 0; k < HORN_N; k++) begin : g_horn
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         uvsg_horner_cell #(.COEF(HORNER_K[k])) u_horn (
            .clock (clock),
            .en    (adv),
            .a_i   (h_a[k][l]),
            .z_i   (h_z[k][l]),
            .z2_i  (h_z2[k][l]),
            .neg_i (h_neg[k][l]),
            .a_o   (h_a[k+1][l]),
            .z_o   (h_z[k+1][l]),
            .z2_o  (h_z2[k+1][l]),
            .neg_o (h_neg[k+1][l])
         );
      end
   end

   // final multiply, round to Q14, cap and sign
   function automatic logic signed [NRM_W-1:0] sine_finish(
      input logic [Z_W-1:0] a,
      input logic [Z_W-1:0] z,
      input logic           neg
   );
      logic [2*Z_W-1:0] p;
      logic [Z_W-1:0]   w;
      logic [15:0]      mag;
      p   = (2*Z_W)'(a) * (2*Z_W)'(z);
      w   = p[FRAC+Z_W-1:FRAC] + Z_W'(32768);
      mag = (w[31:16] > 16'd16384) ? 16'd16384 : w[31:16];
      return neg ? -$signed(NRM_W'(mag)) : $signed(NRM_W'(mag));
   endfunction

   // round half away from zero, 14 fraction bits
   function automatic logic signed [39:0] rnd14(input logic signed [39:0] p);
      logic signed [39:0] q;
      if (p >= 0) begin
         q = (p + 40'sd8192) >>> 14;
      end else begin
         q = -((-p + 40'sd8192) >>> 14);
      end
      return q;
   endfunction

   logic signed [NRM_W-1:0] sin_ff [LANES];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            sin_ff[l] <= sine_finish(h_a[HORN_N][l], h_z[HORN_N][l], h_neg[HORN_N][l]);
         end
      end
   end

   // normals: lanes are sin theta, cos theta, sin phi, cos phi
   logic signed [NRM_W-1:0] nx_ff, ny_ff, nz_ff;
   logic signed [NRM_W-1:0] nx2_ff, ny2_ff, nz2_ff;
   logic signed [POS_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [RAD_W:0]   rad_s;

   assign rad_s = {1'b0, radius_ff};

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff  <= NRM_W'(rnd14(40'(sin_ff[0]) * 40'(sin_ff[3])));
         ny_ff  <= sin_ff[1];
         nz_ff  <= NRM_W'(rnd14(40'(sin_ff[0]) * 40'(sin_ff[2])));
         nx2_ff <= nx_ff;
         ny2_ff <= ny_ff;
         nz2_ff <= nz_ff;
         px_ff  <= POS_W'(rnd14(40'(nx_ff) * 40'(rad_s)));
         py_ff  <= POS_W'(rnd14(40'(ny_ff) * 40'(rad_s)));
         pz_ff  <= POS_W'(rnd14(40'(nz_ff) * 40'(rad_s)));
      end
   end

   // hand over to the output sequencer
   assign adv = !vld_ff[ST_LAST] || ld_ok;

   always_comb begin
      ld.load      = vld_ff[ST_LAST] && ld_ok;
      ld.item.side = side_ff[ST_LAST];
      ld.item.nx   = nx2_ff;
      ld.item.ny   = ny2_ff;
      ld.item.nz   = nz2_ff;
      ld.item.px   = px_ff;
      ld.item.py   = py_ff;
      ld.item.pz   = pz_ff;
      ld.item.tu   = tu_ff[ST_LAST];
      ld.item.tv   = tv_ff[ST_LAST];
   end

   uvsg_out_seq u_out (
      .clock      (clock),
      .reset      (reset),
      .ld_i       (ld),
      .ld_ok_o    (ld_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `UVSG_ASSERT_NXT(a_tri_pair, clock, reset, rsp_tvalid && rsp_tready && (rsp_tuser == KIND_TRI_MORE), rsp_tvalid && (rsp_tuser == KIND_TRI_LAST))
   `UVSG_ASSERT_NXT(a_vert_then_tri, clock, reset, rsp_tvalid && rsp_tready && (rsp_tuser == KIND_VERT_MORE), rsp_tvalid && ((rsp_tuser == KIND_TRI_MORE) || (rsp_tuser == KIND_TRI_LAST)))
   `UVSG_ASSERT_NXT(a_stall_hold, clock, reset, vld_ff[ST_LAST] && !adv, vld_ff[ST_LAST] && $stable(side_ff[ST_LAST]))
   `UVSG_ASSERT_IMP(a_load_free, clock, reset, ld.load, !rsp_tvalid || rsp_tready)

endmodule
